// ===== src/plhd_pkg.sv =====
// shared types and constants of the peak level meter with hold and decay
// depends on nothing; every other file but plhd_queue refers to it by scoped names
package plhd_pkg;

   // payload widths
   localparam int SAMPLE_WIDTH   = 24;
   localparam int DB_WIDTH       = 16;
   localparam int DECAY_WIDTH    = 18;
   localparam int HOLD_WIDTH     = 24;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 1;

   // defaults handed to the top level parameters
   localparam int ELAPSED_WIDTH = 24;
   localparam int QUEUE_DEPTH   = 4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECAY_STEP   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_SAMPLES = 1'b1;

   // register reset values
   localparam int DECAY_RESET = 27;
   localparam int HOLD_RESET  = 2400;

   // level range in 1/256 dB
   localparam int DB_FLOOR = -25600;
   localparam int DB_CEIL  = 4624;

   // log conversion
   localparam int EXP_WIDTH      = $clog2(SAMPLE_WIDTH);
   localparam int NORM_WIDTH     = 32;
   localparam int NORM_SHIFT_W   = $clog2(NORM_WIDTH);
   localparam int LOG_FRAC_BITS  = 24;
   localparam int LOG_INT_WIDTH  = 6;
   localparam int UNITY_LOG2     = 20;
   localparam int DB_COEF_WIDTH  = 28;
   localparam logic signed [DB_COEF_WIDTH-1:0] DB_PER_LOG2_Q24 = 28'sd101008905;
   localparam int DB_SHIFT       = 40;

   // decay accumulator, saturated well beyond the level range
   localparam int ACC_WIDTH = 28;
   localparam int ACC_LIMIT = 2 ** 26;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           block_end;
   } req_type;

   typedef struct packed {
      logic signed [DB_WIDTH-1:0] level_db;
      logic                       clipped;
   } rsp_type;

   // item between front and back
   typedef struct packed {
      logic                    block_end;
      logic [SAMPLE_WIDTH-1:0] peak_mag;
   } item_type;

   // log pipeline output towards the meter state
   typedef struct packed {
      logic                       valid;
      logic                       block_end;
      logic signed [DB_WIDTH-1:0] db;
   } log_result_type;

endpackage

// ===== src/plhd_queue.sv =====
// small first-in first-out queue of register slots
// generic entry type; used between front and back and on the result side
module plhd_queue #(
   parameter int  DEPTH = 4,
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/plhd_front.sv =====
// front end: takes sample items, forms magnitudes and the running block maximum
// uses plhd_pkg types; feeds the queue in front of the log pipeline
module plhd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               stall,
   input  plhd_pkg::req_type  req_data,
   output logic               item_push,
   output plhd_pkg::item_type item
);

   localparam int SW = plhd_pkg::SAMPLE_WIDTH;

   logic [SW-1:0] block_max_ff, block_max_in;
   logic [SW-1:0] mag;
   logic [SW-1:0] max_now;
   logic          accept;

   assign accept = req_push && !stall;

   // magnitude; the most negative sample gives 2^(SW-1)
   always_comb begin
      mag = req_data.sample[SW-1] ? (~unsigned'(req_data.sample) + 1'b1)
                                  : unsigned'(req_data.sample);
      max_now = (mag > block_max_ff) ? mag : block_max_ff;
      block_max_in = block_max_ff;
      if (accept) begin
         block_max_in = req_data.block_end ? '0 : max_now;
      end
   end

   // every item goes on; only a block end carries a meaningful peak
   assign item_push      = accept;
   assign item.block_end = req_data.block_end;
   assign item.peak_mag  = max_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_max_ff <= '0;
      end else begin
         block_max_ff <= block_max_in;
      end
   end

endmodule

// ===== src/plhd_log.sv =====
// log pipeline: block peak magnitude to level in 1/256 dB
// one squaring per stage for each fraction bit; uses plhd_pkg constants
module plhd_log (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  plhd_pkg::item_type       in_item,
   output plhd_pkg::log_result_type out_result
);

   localparam int SW    = plhd_pkg::SAMPLE_WIDTH;
   localparam int EXP_W = plhd_pkg::EXP_WIDTH;
   localparam int NW    = plhd_pkg::NORM_WIDTH;
   localparam int FB    = plhd_pkg::LOG_FRAC_BITS;
   localparam int LI_W  = plhd_pkg::LOG_INT_WIDTH;
   localparam int LG_W  = LI_W + FB;
   localparam int P_W   = LG_W + plhd_pkg::DB_COEF_WIDTH;
   localparam int SH    = plhd_pkg::DB_SHIFT;
   localparam int R_W   = P_W - SH;
   localparam int DB_W  = plhd_pkg::DB_WIDTH;
   localparam logic signed [P_W-1:0] HALF_LSB =
      {{(P_W - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
   localparam logic signed [R_W-1:0] R_LO = R_W'(plhd_pkg::DB_FLOOR);
   localparam logic signed [R_W-1:0] R_HI = R_W'(plhd_pkg::DB_CEIL);

   // leading one stage
   logic             a_valid_ff;
   logic             a_be_ff;
   logic [SW-1:0]    a_mag_ff;
   logic [EXP_W-1:0] a_exp_ff;
   logic [EXP_W-1:0] msb_pos;

   // squaring chain, stage 0 holds the normalised mantissa
   logic [FB:0]      ch_valid_ff;
   logic [FB:0]      ch_be_ff;
   logic [FB:0]      ch_zero_ff;
   logic [EXP_W-1:0] ch_exp_ff  [FB+1];
   logic [NW-1:0]    ch_x_ff    [FB+1];
   logic [FB-1:0]    ch_frac_ff [FB+1];
   logic [NW-1:0]    x_in       [FB+1];
   logic [FB-1:0]    frac_in    [FB+1];
   logic [2*NW-1:0]  sq_w       [FB+1];
   logic [NW:0]      sq_top     [FB+1];

   localparam int NORM_SHIFT_W_L = plhd_pkg::NORM_SHIFT_W;
   logic [NORM_SHIFT_W_L-1:0] norm_shift;

   // scaling product and rounded level
   logic                   c_valid_ff, c_be_ff, c_zero_ff;
   logic signed [P_W-1:0]  c_prod_ff;
   logic [LI_W-1:0]        lg_int;
   logic signed [LG_W-1:0] lg;
   logic                   d_valid_ff, d_be_ff;
   logic signed [DB_W-1:0] d_db_ff, db_in;
   logic signed [P_W-1:0]  prod_round;
   logic signed [R_W-1:0]  db_wide;

   // position of the leading one
   always_comb begin
      msb_pos = '0;
      for (int i = 0; i < SW; i++) begin
         if (in_item.peak_mag[i]) begin
            msb_pos = EXP_W'(i);
         end
      end
   end

   assign norm_shift = NORM_SHIFT_W_L'(NW - 1) - NORM_SHIFT_W_L'(a_exp_ff);

   // one squaring per stage, one fraction bit out of each
   always_comb begin
      x_in[0]    = NW'(a_mag_ff) << norm_shift;
      frac_in[0] = '0;
      sq_w[0]    = '0;
      sq_top[0]  = '0;
      for (int k = 1; k <= FB; k++) begin
         sq_w[k]    = ch_x_ff[k-1] * ch_x_ff[k-1];
         sq_top[k]  = sq_w[k][2*NW-1:NW-1];
         x_in[k]    = sq_top[k][NW] ? sq_top[k][NW:1] : sq_top[k][NW-1:0];
         frac_in[k] = {ch_frac_ff[k-1][FB-2:0], sq_top[k][NW]};
      end
   end

   // log2 in q24, scaled to dB
   assign lg_int = LI_W'(ch_exp_ff[FB]) - LI_W'(plhd_pkg::UNITY_LOG2);
   assign lg     = signed'({lg_int, ch_frac_ff[FB]});

   // round half up, clamp, empty block sits at the floor
   always_comb begin
      prod_round = c_prod_ff + HALF_LSB;
      db_wide    = prod_round[P_W-1:SH];
      if (c_zero_ff || db_wide < R_LO) begin
         db_in = DB_W'(plhd_pkg::DB_FLOOR);
      end else if (db_wide > R_HI) begin
         db_in = DB_W'(plhd_pkg::DB_CEIL);
      end else begin
         db_in = db_wide[DB_W-1:0];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         ch_valid_ff <= '0;
         c_valid_ff  <= 1'b0;
         d_valid_ff  <= 1'b0;
      end else if (adv) begin
         a_valid_ff  <= in_valid;
         ch_valid_ff <= {ch_valid_ff[FB-1:0], a_valid_ff};
         c_valid_ff  <= ch_valid_ff[FB];
         d_valid_ff  <= c_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_be_ff    <= in_item.block_end;
         a_mag_ff   <= in_item.peak_mag;
         a_exp_ff   <= msb_pos;
         ch_be_ff   <= {ch_be_ff[FB-1:0], a_be_ff};
         ch_zero_ff <= {ch_zero_ff[FB-1:0], (a_mag_ff == '0)};
         ch_exp_ff[0] <= a_exp_ff;
         for (int k = 1; k <= FB; k++) begin
            ch_exp_ff[k] <= ch_exp_ff[k-1];
         end
         for (int k = 0; k <= FB; k++) begin
            ch_x_ff[k]    <= x_in[k];
            ch_frac_ff[k] <= frac_in[k];
         end
         c_be_ff   <= ch_be_ff[FB];
         c_zero_ff <= ch_zero_ff[FB];
         c_prod_ff <= lg * plhd_pkg::DB_PER_LOG2_Q24;
         d_be_ff   <= c_be_ff;
         d_db_ff   <= db_in;
      end
   end

   assign out_result.valid     = d_valid_ff;
   assign out_result.block_end = d_be_ff;
   assign out_result.db        = d_db_ff;

endmodule

// ===== src/plhd_meter.sv =====
// meter state: stored peak, elapsed count, decay accumulator, clip flag, registers
// uses plhd_pkg types; takes one log result per advancing cycle
module plhd_meter #(
   parameter int ELAPSED_WIDTH = plhd_pkg::ELAPSED_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [plhd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [plhd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic                                  adv,
   input  plhd_pkg::log_result_type              log_result,
   output logic                                  busy,
   output plhd_pkg::rsp_type                     result
);

   localparam int EW     = ELAPSED_WIDTH;
   localparam int DW     = plhd_pkg::DECAY_WIDTH;
   localparam int HW     = plhd_pkg::HOLD_WIDTH;
   localparam int DIFF_W = (EW > HW) ? EW : HW;
   localparam int PROD_W = DW + DIFF_W + 1;
   localparam int ACC_W  = plhd_pkg::ACC_WIDTH;
   localparam int V_W    = ACC_W + 1;
   localparam int DB_W   = plhd_pkg::DB_WIDTH;
   localparam logic signed [ACC_W-1:0]  ACC_HI  = ACC_W'(plhd_pkg::ACC_LIMIT);
   localparam logic signed [ACC_W-1:0]  ACC_LO  = -ACC_HI;
   localparam logic signed [V_W-1:0]    SUM_HI  = V_W'(plhd_pkg::ACC_LIMIT);
   localparam logic signed [V_W-1:0]    SUM_LO  = -SUM_HI;
   localparam logic signed [PROD_W-1:0] PROD_HI = PROD_W'(plhd_pkg::ACC_LIMIT);
   localparam logic signed [PROD_W-1:0] PROD_LO = -PROD_HI;
   localparam logic signed [V_W-1:0]    V_LO    = V_W'(plhd_pkg::DB_FLOOR * 256);
   localparam logic signed [V_W-1:0]    V_HI    = V_W'(plhd_pkg::DB_CEIL * 256);
   localparam logic signed [V_W-1:0]    V_HALF  = V_W'(128);
   localparam logic [EW-1:0]            N_MAX   = {EW{1'b1}};

   logic signed [DW-1:0]     decay_ff;
   logic [HW-1:0]            hold_ff;
   logic signed [DB_W-1:0]   stored_ff, stored_in;
   logic [EW-1:0]            elapsed_ff, elapsed_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     clip_ff, clip_in;
   logic [1:0]               sync_cnt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  prod_sat;

   logic                     update;
   logic [DIFF_W-1:0]        diff;
   logic signed [V_W-1:0]    v, vc, v_round;
   logic signed [DB_W-1:0]   cur;
   logic                     take;
   logic signed [DB_W-1:0]   level;
   logic [EW-1:0]            elapsed_mid;
   logic signed [ACC_W-1:0]  acc_mid;
   logic signed [V_W-1:0]    acc_sum;
   logic signed [ACC_W-1:0]  acc_step;
   logic                     past_hold;

   assign update = adv && log_result.valid;
   assign busy   = (sync_cnt_ff != 2'd0);

   // decay accumulator rebuilt from scratch after reset or a register write
   always_comb begin
      diff = (DIFF_W'(elapsed_ff) >= DIFF_W'(hold_ff))
             ? DIFF_W'(elapsed_ff) - DIFF_W'(hold_ff) : '0;
      if (prod_ff > PROD_HI) begin
         prod_sat = ACC_HI;
      end else if (prod_ff < PROD_LO) begin
         prod_sat = ACC_LO;
      end else begin
         prod_sat = ACC_W'(prod_ff);
      end
   end

   // shown level from the state before this item
   always_comb begin
      v = (V_W'(stored_ff) <<< 8) - V_W'(acc_ff);
      if (v < V_LO) begin
         vc = V_LO;
      end else if (v > V_HI) begin
         vc = V_HI;
      end else begin
         vc = v;
      end
      v_round = (vc + V_HALF) >>> 8;
      cur     = v_round[DB_W-1:0];
   end

   // block end compare, then elapsed count and decay step
   always_comb begin
      take    = 1'b0;
      level   = cur;
      clip_in = clip_ff;
      if (log_result.block_end) begin
         take = decay_ff[DW-1] ? (log_result.db < cur) : (log_result.db > cur);
         if (log_result.db > DB_W'(0)) begin
            clip_in = 1'b1;
         end
         if (take) begin
            level = log_result.db;
         end
      end
      stored_in   = take ? log_result.db : stored_ff;
      elapsed_mid = take ? '0 : elapsed_ff;
      acc_mid     = take ? '0 : acc_ff;
      acc_sum     = V_W'(acc_mid) + V_W'(decay_ff);
      if (acc_sum > SUM_HI) begin
         acc_step = ACC_HI;
      end else if (acc_sum < SUM_LO) begin
         acc_step = ACC_LO;
      end else begin
         acc_step = ACC_W'(acc_sum);
      end
      past_hold  = (elapsed_mid != N_MAX) &&
                   (DIFF_W'(elapsed_mid) >= DIFF_W'(hold_ff));
      elapsed_in = (elapsed_mid == N_MAX) ? elapsed_mid : elapsed_mid + 1'b1;
      acc_in     = past_hold ? acc_step : acc_mid;
   end

   assign result.level_db = level;
   assign result.clipped  = clip_in;

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff    <= DW'(plhd_pkg::DECAY_RESET);
         hold_ff     <= HW'(plhd_pkg::HOLD_RESET);
         stored_ff   <= DB_W'(plhd_pkg::DB_FLOOR);
         elapsed_ff  <= N_MAX;
         clip_ff     <= 1'b0;
         sync_cnt_ff <= 2'd2;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               plhd_pkg::CSR_DECAY_STEP: begin
                  decay_ff <= signed'(csr_wdata[DW-1:0]);
               end
               plhd_pkg::CSR_HOLD_SAMPLES: begin
                  hold_ff <= csr_wdata[HW-1:0];
               end
               default: begin
                  hold_ff <= hold_ff;
               end
            endcase
            sync_cnt_ff <= 2'd2;
         end else if (sync_cnt_ff != 2'd0) begin
            sync_cnt_ff <= sync_cnt_ff - 2'd1;
         end
         if (update) begin
            stored_ff  <= stored_in;
            elapsed_ff <= elapsed_in;
            clip_ff    <= clip_in;
         end
      end
   end

   // decay product and accumulator
   always_ff @(posedge clock) begin
      prod_ff <= decay_ff * signed'({1'b0, diff});
      if (sync_cnt_ff == 2'd1) begin
         acc_ff <= prod_sat;
      end else if (update) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== src/peak_level_hold_decay_meter_unit.sv =====
// top level of the peak level meter with hold and decay
// instantiates plhd_front, plhd_queue, plhd_log and plhd_meter; uses plhd_pkg
//
//   channel   ports                              direction  moves
//   request   req_push, req_full, req_data       in         sample item
//   response  rsp_pop, rsp_empty, rsp_data       out        level and clip item
//   control   csr_write_en, csr_index, csr_wdata in         register write
//
// one item per cycle sustained while req_full is low; an item's result reaches rsp_data
// through the log pipeline (one squaring stage per fraction bit) and the result queue.
// after reset and after each register write req_full stays high while the decay
// accumulator is rebuilt by its multiplier.
// a full result queue holds the whole back pipeline while a finished item waits;
// the front queue then fills and raises req_full.
module peak_level_hold_decay_meter_unit #(
   parameter int ELAPSED_WIDTH = plhd_pkg::ELAPSED_WIDTH,
   parameter int QUEUE_DEPTH   = plhd_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  plhd_pkg::req_type                    req_data,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output plhd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_en,
   input  logic [plhd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [plhd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                     item_push;
   plhd_pkg::item_type       item;
   logic                     mid_full, mid_empty;
   plhd_pkg::item_type       mid_item;
   logic                     adv;
   plhd_pkg::log_result_type log_result;
   logic                     meter_busy;
   plhd_pkg::rsp_type        meter_result;
   logic                     out_full;

   // back pipeline moves unless a finished item has nowhere to go
   assign adv      = !(out_full && log_result.valid);
   assign req_full = mid_full || meter_busy;

   // front: magnitude and block maximum
   plhd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .stall     (req_full),
      .req_data  (req_data),
      .item_push (item_push),
      .item      (item)
   );

   // queue between front and back
   plhd_queue #(
      .DEPTH      (QUEUE_DEPTH),
      .entry_type (plhd_pkg::item_type)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (item),
      .full      (mid_full),
      .pop       (adv),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   // back: log conversion
   plhd_log u_log (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (!mid_empty),
      .in_item    (mid_item),
      .out_result (log_result)
   );

   // back: meter state
   plhd_meter #(
      .ELAPSED_WIDTH (ELAPSED_WIDTH)
   ) u_meter (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .adv          (adv),
      .log_result   (log_result),
      .busy         (meter_busy),
      .result       (meter_result)
   );

   // result queue
   plhd_queue #(
      .DEPTH      (QUEUE_DEPTH),
      .entry_type (plhd_pkg::rsp_type)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (adv && log_result.valid),
      .push_data (meter_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
